>>> rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int IDX_W    = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic REG_ATTR = 1'b0;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
        logic              in_range;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_FILL
    } t_state;

endpackage

>>> rtl/text_console_char_writer.sv
// Text console engine: a COLUMNS by ROWS store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a linear cursor.
// Input channel (i_valid/o_ready) takes one item: i_func selects put character,
// read cell or clear screen. Output channel (o_valid/i_ready) returns one item per
// input item: the cell read, the cursor after the item and a scroll flag.
// The attribute register sits at APB address 0; write it only while idle.
// Items pass through a two-entry queue to the execution unit, so the input side
// keeps accepting while a result waits at the output register.
// A put, newline, return, backspace, out-of-range read or unused selector loads the
// output register from the idle state; an in-range read first takes the registered
// cell data in the read state. A put, newline or column-0 backspace that runs past
// the last cell scrolls, one cell copied per cycle through the single write port of
// the cell store, before its result is shown. A clear fills the store with spaces,
// one cell written per cycle, before its result is shown.
// Throughput: one item per cycle while nothing scrolls or clears and the receiver
// takes each result; an in-range read also passes through the read state.
// After reset the store is filled with blanks while o_ready is low; configuration
// writes are taken throughout.
// When the receiver stalls, the result holds; up to two further items are queued.
module text_console_char_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic [IDX_W-1:0]    i_cell_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CELL_W-1:0]   o_cell_data,
    output logic [CURSOR_W-1:0] o_cursor_pos,
    output logic                o_scrolled,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [ATTR_W-1:0] r_attr;
    t_cmd              front_cmd;
    t_cmd              queue_cmd;
    t_q_status         q_status;
    logic              push;
    logic              pop;
    logic              init_done;
    logic              attr_sel;

    assign pready   = 1'b1;
    assign attr_sel = paddr[2] == REG_ATTR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && attr_sel) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = attr_sel ? {24'd0, r_attr} : 32'd0;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_valid      (i_valid),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_q_status   (q_status),
        .i_init_done  (init_done),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_q_status   (q_status),
        .i_cmd        (queue_cmd),
        .o_pop        (pop),
        .o_init_done  (init_done),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cell_data  (o_cell_data),
        .o_cursor_pos (o_cursor_pos),
        .o_scrolled   (o_scrolled)
    );

endmodule

>>> rtl/tcw_front.sv
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_valid,
    input  logic [1:0]        i_func,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    input  t_q_status         i_q_status,
    input  logic              i_init_done,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam int CC = COLUMNS * ROWS;
    localparam int AW = $clog2(CC);
    localparam int WW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    t_op op;

    always_comb begin
        unique case (i_func)
            FUNC_PUT: begin
                priority if (i_char_code == CH_NEWLINE) begin
                    op = OP_NEWLINE;
                end else if (i_char_code == CH_RETURN) begin
                    op = OP_RETURN;
                end else if (i_char_code == CH_BACKSPACE) begin
                    op = OP_BACKSPACE;
                end else begin
                    op = OP_PUT;
                end
            end
            FUNC_READ:  op = OP_READ;
            FUNC_CLEAR: op = OP_CLEAR;
            default:    op = OP_NOP;
        endcase
    end

    assign o_cmd.op         = op;
    assign o_cmd.char_code  = i_char_code;
    assign o_cmd.cell_index = i_cell_index;
    assign o_cmd.in_range   = WW'(i_cell_index) < WW'(CC);

    // No item is taken while the cell store is still being cleared after reset.
    assign o_ready = !i_q_status.full && i_init_done;
    assign o_push  = i_valid && o_ready;

endmodule

>>> rtl/tcw_queue.sv
module tcw_queue import tcw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd       r_entries [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_count;

    always_comb begin
        n_wp    = i_push ? ~r_wp : r_wp;
        n_rp    = i_pop ? ~r_rp : r_rp;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wp] <= i_cmd;
        end
    end

    assign o_cmd          = r_entries[r_rp];
    assign o_status.full  = r_count == 2'd2;
    assign o_status.valid = r_count != 2'd0;

endmodule

>>> rtl/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ATTR_W-1:0]   i_attr,
    input  t_q_status           i_q_status,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_init_done,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CELL_W-1:0]   o_cell_data,
    output logic [CURSOR_W-1:0] o_cursor_pos,
    output logic                o_scrolled
);

    localparam int CC     = COLUMNS * ROWS;
    localparam int AW     = $clog2(CC);
    localparam int AW1    = AW + 1;
    localparam int CLW    = $clog2(COLUMNS);
    localparam int WW     = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int COPY_N = CC - COLUMNS;

    localparam logic [AW-1:0]  LAST      = AW'(CC - 1);
    localparam logic [AW-1:0]  LAST_ROW  = AW'(COPY_N);
    localparam logic [CLW-1:0] LAST_COL  = CLW'(COLUMNS - 1);

    logic [CELL_W-1:0] r_cells [CC];
    logic [CELL_W-1:0] r_rd_data;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_cursor;
    logic [AW-1:0]      n_cursor;
    logic [CLW-1:0]     r_col;
    logic [CLW-1:0]     n_col;
    logic [AW-1:0]      r_cnt;
    logic [AW-1:0]      n_cnt;

    // Copy stage of the scroll: the cell read in the previous cycle is written here.
    logic               r_wv;
    logic [AW-1:0]      r_wa;
    logic               r_wsrc;

    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_data;
    logic [CURSOR_W-1:0] r_out_cursor;
    logic               r_out_scrolled;

    logic               slot_free;
    logic               pop;
    logic               is_store;
    logic               is_bs_move;
    logic               need_scroll;
    logic [AW1-1:0]     cur_ext;
    logic [AW1-1:0]     cur_next;
    logic [CLW-1:0]     col_next;
    logic [WW-1:0]      idx_wide;

    logic               fsm_we;
    logic [AW-1:0]      fsm_wa;
    logic [CELL_W-1:0]  fsm_wd;
    logic [AW-1:0]      rd_addr;
    logic               out_load;
    logic [CELL_W-1:0]  out_data;
    logic [AW-1:0]      out_cursor;
    logic               out_scrolled;
    logic [WW-1:0]      out_cursor_wide;

    assign slot_free = !r_out_valid || i_ready;
    assign pop       = (r_state == ST_IDLE) && i_q_status.valid && slot_free;
    assign idx_wide  = WW'(i_cmd.cell_index);
    assign cur_ext   = {1'b0, r_cursor};

    always_comb begin
        is_bs_move = (i_cmd.op == OP_BACKSPACE) && (r_col != '0);
        is_store   = (i_cmd.op == OP_PUT) || ((i_cmd.op == OP_BACKSPACE) && (r_col == '0));
        cur_next   = cur_ext;
        col_next   = r_col;
        priority if (i_cmd.op == OP_NEWLINE) begin
            cur_next = cur_ext - AW1'(r_col) + AW1'(COLUMNS);
            col_next = '0;
        end else if (i_cmd.op == OP_RETURN) begin
            cur_next = cur_ext - AW1'(r_col);
            col_next = '0;
        end else if (is_bs_move) begin
            cur_next = cur_ext - AW1'(1);
            col_next = r_col - CLW'(1);
        end else if (is_store) begin
            cur_next = cur_ext + AW1'(1);
            col_next = (r_col == LAST_COL) ? '0 : r_col + CLW'(1);
        end else begin
            cur_next = cur_ext;
        end
        need_scroll = cur_next >= AW1'(CC);
    end

    always_comb begin
        unique case (r_state)
            ST_INIT:       n_state = (r_cnt == LAST) ? ST_IDLE : ST_INIT;
            ST_IDLE: begin
                n_state = ST_IDLE;
                if (pop) begin
                    unique case (i_cmd.op)
                        OP_READ:  n_state = i_cmd.in_range ? ST_READ : ST_IDLE;
                        OP_CLEAR: n_state = ST_FILL;
                        OP_PUT, OP_NEWLINE, OP_RETURN, OP_BACKSPACE:
                            n_state = need_scroll ? ST_SCROLL : ST_IDLE;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:       n_state = ST_IDLE;
            ST_SCROLL:     n_state = (r_cnt == LAST) ? ST_SCROLL_END : ST_SCROLL;
            ST_SCROLL_END: n_state = ST_IDLE;
            ST_FILL:       n_state = (r_cnt == LAST) ? ST_IDLE : ST_FILL;
            default:       n_state = ST_INIT;
        endcase
    end

    always_comb begin
        fsm_we       = 1'b0;
        fsm_wa       = r_cnt;
        fsm_wd       = BLANK_CELL;
        rd_addr      = '0;
        out_load     = 1'b0;
        out_data     = '0;
        out_cursor   = r_cursor;
        out_scrolled = 1'b0;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_cnt        = r_cnt + AW'(1);
        unique case (r_state)
            ST_INIT: begin
                fsm_we = 1'b1;
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (pop) begin
                    unique case (i_cmd.op)
                        OP_READ: begin
                            rd_addr  = idx_wide[AW-1:0];
                            out_load = !i_cmd.in_range;
                        end
                        OP_CLEAR: begin
                        end
                        OP_PUT, OP_NEWLINE, OP_RETURN, OP_BACKSPACE: begin
                            fsm_we     = is_store || is_bs_move;
                            fsm_wa     = is_bs_move ? r_cursor - AW'(1) : r_cursor;
                            fsm_wd     = {i_attr, is_bs_move ? CH_SPACE : i_cmd.char_code};
                            n_cursor   = cur_next[AW-1:0];
                            n_col      = col_next;
                            out_load   = !need_scroll;
                            out_cursor = cur_next[AW-1:0];
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                out_data = r_rd_data;
            end
            ST_SCROLL: begin
                rd_addr = (r_cnt < LAST_ROW) ? r_cnt + AW'(COLUMNS) : '0;
            end
            ST_SCROLL_END: begin
                n_cursor     = LAST_ROW;
                n_col        = '0;
                out_load     = 1'b1;
                out_cursor   = LAST_ROW;
                out_scrolled = 1'b1;
            end
            ST_FILL: begin
                fsm_we = 1'b1;
                fsm_wd = {i_attr, CH_SPACE};
                if (r_cnt == LAST) begin
                    n_cursor   = '0;
                    n_col      = '0;
                    out_load   = 1'b1;
                    out_cursor = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cursor    <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_wv     <= r_state == ST_SCROLL;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_cursor_wide = WW'(out_cursor);

    always_ff @(posedge i_clk) begin
        r_wa   <= r_cnt;
        r_wsrc <= r_cnt < LAST_ROW;
        if (out_load) begin
            r_out_data     <= out_data;
            r_out_cursor   <= out_cursor_wide[CURSOR_W-1:0];
            r_out_scrolled <= out_scrolled;
        end
    end

    // Cell store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            r_cells[r_wa] <= r_wsrc ? r_rd_data : BLANK_CELL;
        end else if (fsm_we) begin
            r_cells[fsm_wa] <= fsm_wd;
        end
        r_rd_data <= r_cells[rd_addr];
    end

    assign o_pop        = pop;
    assign o_init_done  = r_state != ST_INIT;
    assign o_valid      = r_out_valid;
    assign o_cell_data  = r_out_data;
    assign o_cursor_pos = r_out_cursor;
    assign o_scrolled   = r_out_scrolled;

endmodule

>>> rtl/tcw_checker.sv
module tcw_checker import tcw_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [CELL_W-1:0]   o_cell_data,
    input logic [CURSOR_W-1:0] o_cursor_pos,
    input logic                o_scrolled
);

    // The cell store is being cleared straight after reset, so no item is taken.
    a_no_accept_after_reset: assert property (
        @(posedge i_clk) (i_rst_n && $past(!i_rst_n)) |-> !o_ready
    ) else $error("input accepted during the clearing pass");

    a_no_result_after_reset: assert property (
        @(posedge i_clk) (i_rst_n && $past(!i_rst_n)) |-> !o_valid
    ) else $error("result shown straight after reset");

    // Only a put, newline or backspace can scroll, and these never return cell data.
    a_scroll_no_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (o_cell_data == '0)
    ) else $error("scrolled result carries cell data");

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_cell_data) && $stable(o_cursor_pos) && $stable(o_scrolled))
    ) else $error("stalled result changed");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_cell_data  (o_cell_data),
    .o_cursor_pos (o_cursor_pos),
    .o_scrolled   (o_scrolled)
);
